FILE: rtl/core/vat_pkg.sv
// Package for the vertex affine transform unit: payload types, codes,
// controller state enum, command/status structs and fixed-point helpers.
// No dependencies.
package vat_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CNT_WIDTH   = 5;

    // 0.2 in the coordinate format and the scale numerator 0.2 * ONE
    localparam logic [31:0] ONE_Q   = 32'd65536;
    localparam logic [31:0] STEP_Q  = 32'd13107;
    localparam logic [31:0] NUM_MAG = 32'd858980352;

    // degree-to-radian constant (Q32) and inverse CORDIC gain (Q30)
    localparam logic [26:0] DEG_TO_RAD = 27'd74961321;
    localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

    // register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_AXIS   = 2'd1;
    localparam logic [1:0] REG_DIR    = 2'd2;
    localparam logic [1:0] REG_AMOUNT = 2'd3;

    // modes and axes
    localparam logic [1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [1:0] MODE_SCALE     = 2'd1;
    localparam logic [1:0] MODE_ROTATE    = 2'd2;
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // coefficient selects for the shared multiplier
    localparam logic [1:0] COEF_COS    = 2'd0;
    localparam logic [1:0] COEF_SIN    = 2'd1;
    localparam logic [1:0] COEF_NSIN   = 2'd2;
    localparam logic [1:0] COEF_FACTOR = 2'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_in;
        logic signed [COORD_WIDTH-1:0] y_in;
        logic signed [COORD_WIDTH-1:0] z_in;
        logic                          last_vertex;
    } t_vtx_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
        logic signed [COORD_WIDTH-1:0] z_out;
        logic                          last_out;
        logic                          scale_fault;
    } t_vtx_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MODDIV,
        ST_RAD,
        ST_ZLOAD,
        ST_CORDIC,
        ST_SFIN,
        ST_MUL,
        ST_ACC,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                 accept;
        logic                 moddiv;
        logic                 rad;
        logic                 zload;
        logic                 cordic;
        logic                 sfin;
        logic                 mul;
        logic                 finish;
        logic [CNT_WIDTH-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic       batch_ready;
        logic [2:0] n_steps;
        logic       out_free;
    } t_status;

    // saturate a wide signed value to the coordinate width
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh7FFF_FFFF;
        lo = -hi - 66'sd1;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // arctangent table in Q30
    function automatic logic signed [33:0] atan_entry(input logic [CNT_WIDTH-1:0] i);
        case (i)
            5'd0:    atan_entry = 34'sd843314856;
            5'd1:    atan_entry = 34'sd497837829;
            5'd2:    atan_entry = 34'sd263043836;
            5'd3:    atan_entry = 34'sd133525158;
            5'd4:    atan_entry = 34'sd67021686;
            5'd5:    atan_entry = 34'sd33543515;
            5'd6:    atan_entry = 34'sd16775850;
            5'd7:    atan_entry = 34'sd8388437;
            5'd8:    atan_entry = 34'sd4194282;
            5'd9:    atan_entry = 34'sd2097149;
            5'd31:   atan_entry = 34'sd0;
            default: atan_entry = (34'sd1 <<< (5'd30 - i)) - 34'sd1;
        endcase
    endfunction

endpackage

FILE: rtl/core/vat_ctrl.sv
// Controller of the vertex affine transform unit: sequences batch setup
// and per-vertex multiply steps. Depends on vat_pkg.
module vat_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  vat_pkg::t_status i_status,
    output vat_pkg::t_cmd    o_cmd
);

    localparam logic [vat_pkg::CNT_WIDTH-1:0] CNT_LAST = '1;
    localparam logic [vat_pkg::CNT_WIDTH-1:0] CORDIC_LAST =
        vat_pkg::CNT_WIDTH'(CORDIC_STEPS - 1);

    vat_pkg::t_state r_state, n_state;
    logic [vat_pkg::CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [vat_pkg::CNT_WIDTH-1:0] w_mul_last;

    assign w_mul_last = vat_pkg::CNT_WIDTH'(i_status.n_steps) - 1'b1;

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vat_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            vat_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    if (!i_status.batch_ready) begin
                        n_state = vat_pkg::ST_MODDIV;
                    end else if (i_status.n_steps == 3'd0) begin
                        n_state = vat_pkg::ST_FIN;
                    end else begin
                        n_state = vat_pkg::ST_MUL;
                    end
                end
            end
            vat_pkg::ST_MODDIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = vat_pkg::ST_RAD;
                end
            end
            vat_pkg::ST_RAD: begin
                n_state = vat_pkg::ST_ZLOAD;
            end
            vat_pkg::ST_ZLOAD: begin
                n_cnt   = '0;
                n_state = vat_pkg::ST_CORDIC;
            end
            vat_pkg::ST_CORDIC: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CORDIC_LAST) begin
                    n_state = vat_pkg::ST_SFIN;
                end
            end
            vat_pkg::ST_SFIN: begin
                n_cnt = '0;
                if (i_status.n_steps == 3'd0) begin
                    n_state = vat_pkg::ST_FIN;
                end else begin
                    n_state = vat_pkg::ST_MUL;
                end
            end
            vat_pkg::ST_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == w_mul_last) begin
                    n_state = vat_pkg::ST_ACC;
                end
            end
            vat_pkg::ST_ACC: begin
                n_state = vat_pkg::ST_FIN;
            end
            vat_pkg::ST_FIN: begin
                if (i_status.out_free) begin
                    n_state = vat_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vat_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.cnt  = r_cnt;
        o_in_ready = 1'b0;
        case (r_state)
            vat_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            vat_pkg::ST_MODDIV: o_cmd.moddiv = 1'b1;
            vat_pkg::ST_RAD:    o_cmd.rad    = 1'b1;
            vat_pkg::ST_ZLOAD:  o_cmd.zload  = 1'b1;
            vat_pkg::ST_CORDIC: o_cmd.cordic = 1'b1;
            vat_pkg::ST_SFIN:   o_cmd.sfin   = 1'b1;
            vat_pkg::ST_MUL:    o_cmd.mul    = 1'b1;
            vat_pkg::ST_FIN:    o_cmd.finish = i_status.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/vat_datapath.sv
// Datapath of the vertex affine transform unit: configuration registers,
// angle reduction, divider, CORDIC, shared multiplier and output register.
// Depends on vat_pkg.
module vat_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_wdata,
    input  vat_pkg::t_vtx_in i_in,
    input  vat_pkg::t_cmd    i_cmd,
    output vat_pkg::t_status o_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output vat_pkg::t_vtx_out o_out
);

    localparam logic signed [26:0] FULL    = 27'sd23592960;
    localparam logic signed [26:0] HALF    = 27'sd11796480;
    localparam logic signed [26:0] QUARTER = 27'sd5898240;

    // degrees in a turn and its reciprocal in Q24, exact for 16-bit degrees
    localparam logic [15:0] DEG_TURN  = 16'd360;
    localparam logic [15:0] TURN_RECIP = 16'd46604;

    // configuration and persistent state
    logic [1:0]         r_mode, r_axis, r_dir;
    logic signed [31:0] r_amount;
    logic signed [31:0] r_slevel, r_cos, r_sin, r_factor;
    logic               r_batch, r_fault;

    // captured vertex
    vat_pkg::t_vtx_in   r_vin;

    // modulo and divider
    logic [31:0] r_mq, r_dq, r_drem, r_dv;
    logic [25:0] r_mrem;
    logic [6:0]  r_mquo;
    logic        r_asign, r_qsign;

    // radian conversion and CORDIC
    logic [49:0]        r_prad;
    logic               r_flip, r_rneg;
    logic signed [33:0] r_cx, r_cy, r_cz;

    // multiplier and accumulators
    logic signed [64:0] r_prod;
    logic [1:0]         r_tgt;
    logic               r_pv;
    logic signed [65:0] r_acc [0:2];
    logic [2:0]         r_used;

    // output register
    vat_pkg::t_vtx_out  r_out;
    logic               r_ovalid;

    logic w_dneg;
    assign w_dneg = r_dir[1];

    // step count for the current mode
    always_comb begin
        o_status.n_steps = 3'd0;
        if (r_mode == vat_pkg::MODE_SCALE) begin
            o_status.n_steps = 3'd3;
        end else if (r_mode == vat_pkg::MODE_ROTATE && r_axis != 2'd3) begin
            o_status.n_steps = 3'd4;
        end
    end
    assign o_status.batch_ready = r_batch;
    assign o_status.out_free    = !r_ovalid || i_out_ready;

    // setup start values
    logic signed [32:0] w_amt, w_a;
    logic [31:0]        w_amag, w_slmag;
    always_comb begin
        w_amt   = 33'(r_amount);
        w_a     = w_dneg ? w_amt : -w_amt;
        w_amag  = w_a[32] ? 32'(-w_a) : w_a[31:0];
        w_slmag = r_slevel[31] ? 32'(-r_slevel) : r_slevel;
    end

    // modulo 360 on the whole degrees by reciprocal; one bit of the scale division
    logic [31:0] w_mprod;
    logic [15:0] w_mqx;
    logic [8:0]  w_mr9;
    logic [32:0] w_dt;
    logic        w_dbit;
    always_comb begin
        w_mprod = 32'(r_mq[31:16]) * 32'(TURN_RECIP);
        w_mqx   = 16'(r_mquo) * DEG_TURN;
        w_mr9   = 9'(r_mq[31:16] - w_mqx);
        w_dt    = {r_drem, r_dq[31]};
        w_dbit  = (w_dt >= {1'b0, r_dv});
    end

    // fold angle into [-90,90] and scale it to radians
    logic signed [26:0] w_rr, w_rmag;
    logic               w_flip;
    logic signed [32:0] w_q;
    logic signed [33:0] w_f;
    always_comb begin
        w_rr   = r_asign ? -$signed({1'b0, r_mrem}) : $signed({1'b0, r_mrem});
        w_flip = 1'b0;
        if (w_rr < 0) begin
            w_rr = w_rr + FULL;
        end
        if (w_rr >= HALF) begin
            w_rr = w_rr - FULL;
        end
        if (w_rr > QUARTER) begin
            w_rr   = w_rr - HALF;
            w_flip = 1'b1;
        end else if (w_rr < -QUARTER) begin
            w_rr   = w_rr + HALF;
            w_flip = 1'b1;
        end
        w_rmag = (w_rr < 0) ? -w_rr : w_rr;
        w_q    = r_qsign ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
        w_f    = 34'(w_q) + 34'(vat_pkg::ONE_Q);
    end

    // CORDIC step and final rounding
    logic signed [33:0] w_dx, w_dy, w_atan;
    logic signed [34:0] w_xf, w_yf, w_xr, w_yr;
    logic [32:0]        w_z;
    always_comb begin
        w_dx   = r_cy >>> i_cmd.cnt;
        w_dy   = r_cx >>> i_cmd.cnt;
        w_atan = vat_pkg::atan_entry(i_cmd.cnt);
        w_xf   = r_flip ? -35'(r_cx) : 35'(r_cx);
        w_yf   = r_flip ? -35'(r_cy) : 35'(r_cy);
        w_xr   = (w_xf + 35'sd8192) >>> 14;
        w_yr   = (w_yf + 35'sd8192) >>> 14;
        w_z    = 33'((r_prad + 50'd131072) >> 18);
    end

    // select multiplier operands for this step
    logic [1:0]         w_csel, w_vsel, w_tsel;
    logic signed [32:0] w_coef;
    logic signed [31:0] w_coord;
    always_comb begin
        w_csel = vat_pkg::COEF_FACTOR;
        w_vsel = i_cmd.cnt[1:0];
        w_tsel = i_cmd.cnt[1:0];
        if (r_mode == vat_pkg::MODE_ROTATE) begin
            case (r_axis)
                vat_pkg::AXIS_X: begin
                    w_tsel = i_cmd.cnt[1] ? vat_pkg::AXIS_Z : vat_pkg::AXIS_Y;
                    w_vsel = i_cmd.cnt[0] ? vat_pkg::AXIS_Z : vat_pkg::AXIS_Y;
                    case (i_cmd.cnt[1:0])
                        2'd0:    w_csel = vat_pkg::COEF_COS;
                        2'd1:    w_csel = vat_pkg::COEF_NSIN;
                        2'd2:    w_csel = vat_pkg::COEF_SIN;
                        default: w_csel = vat_pkg::COEF_COS;
                    endcase
                end
                vat_pkg::AXIS_Y: begin
                    w_tsel = i_cmd.cnt[1] ? vat_pkg::AXIS_Z : vat_pkg::AXIS_X;
                    w_vsel = i_cmd.cnt[0] ? vat_pkg::AXIS_Z : vat_pkg::AXIS_X;
                    case (i_cmd.cnt[1:0])
                        2'd0:    w_csel = vat_pkg::COEF_COS;
                        2'd1:    w_csel = vat_pkg::COEF_SIN;
                        2'd2:    w_csel = vat_pkg::COEF_NSIN;
                        default: w_csel = vat_pkg::COEF_COS;
                    endcase
                end
                default: begin
                    w_tsel = i_cmd.cnt[1] ? vat_pkg::AXIS_Y : vat_pkg::AXIS_X;
                    w_vsel = i_cmd.cnt[0] ? vat_pkg::AXIS_Y : vat_pkg::AXIS_X;
                    case (i_cmd.cnt[1:0])
                        2'd0:    w_csel = vat_pkg::COEF_COS;
                        2'd1:    w_csel = vat_pkg::COEF_NSIN;
                        2'd2:    w_csel = vat_pkg::COEF_SIN;
                        default: w_csel = vat_pkg::COEF_COS;
                    endcase
                end
            endcase
        end
        case (w_csel)
            vat_pkg::COEF_COS:  w_coef = 33'(r_cos);
            vat_pkg::COEF_SIN:  w_coef = 33'(r_sin);
            vat_pkg::COEF_NSIN: w_coef = -33'(r_sin);
            default:            w_coef = 33'(r_factor);
        endcase
        case (w_vsel)
            vat_pkg::AXIS_X: w_coord = r_vin.x_in;
            vat_pkg::AXIS_Y: w_coord = r_vin.y_in;
            default:         w_coord = r_vin.z_in;
        endcase
    end

    // result assembly
    logic signed [31:0] w_res [0:2];
    logic signed [31:0] w_cin [0:2];
    logic signed [33:0] w_mv;
    logic signed [65:0] w_rnd;
    logic signed [32:0] w_slnext;
    always_comb begin
        w_cin[0] = r_vin.x_in;
        w_cin[1] = r_vin.y_in;
        w_cin[2] = r_vin.z_in;
        w_mv     = w_dneg ? -34'(r_amount) : 34'(r_amount);
        w_slnext = w_dneg ? 33'(r_slevel) - 33'(vat_pkg::STEP_Q)
                          : 33'(r_slevel) + 33'(vat_pkg::STEP_Q);
        w_rnd    = '0;
        for (int i = 0; i < 3; i++) begin
            w_res[i] = w_cin[i];
            if (r_mode == vat_pkg::MODE_TRANSLATE) begin
                if (r_axis == 2'(i)) begin
                    w_res[i] = vat_pkg::sat32(66'(34'(w_cin[i]) + w_mv));
                end
            end else if (r_used[i]) begin
                w_rnd    = (r_acc[i] + 66'sd32768) >>> vat_pkg::FRAC_BITS;
                w_res[i] = vat_pkg::sat32(w_rnd);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= vat_pkg::MODE_TRANSLATE;
            r_axis   <= vat_pkg::AXIS_X;
            r_dir    <= 2'd1;
            r_amount <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vat_pkg::REG_MODE:   r_mode   <= i_cfg_wdata[1:0];
                vat_pkg::REG_AXIS:   r_axis   <= i_cfg_wdata[1:0];
                vat_pkg::REG_DIR:    r_dir    <= i_cfg_wdata[1:0];
                default:             r_amount <= i_cfg_wdata;
            endcase
        end
    end

    // batch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slevel <= 32'(vat_pkg::ONE_Q);
            r_cos    <= '0;
            r_sin    <= '0;
            r_factor <= 32'(vat_pkg::ONE_Q);
            r_batch  <= 1'b0;
            r_fault  <= 1'b0;
        end else begin
            if (i_cmd.rad) begin
                if (r_slevel == '0) begin
                    r_factor <= 32'(vat_pkg::ONE_Q);
                    r_fault  <= 1'b1;
                end else begin
                    r_factor <= vat_pkg::sat32(66'(w_f));
                    r_fault  <= 1'b0;
                end
            end
            if (i_cmd.sfin) begin
                r_cos   <= vat_pkg::sat32(66'(w_xr));
                r_sin   <= vat_pkg::sat32(66'(w_yr));
                r_batch <= 1'b1;
            end
            if (i_cmd.finish && r_vin.last_vertex) begin
                r_batch <= 1'b0;
                if (r_mode == vat_pkg::MODE_SCALE) begin
                    r_slevel <= vat_pkg::sat32(66'(w_slnext));
                end
            end
        end
    end

    // setup datapath: modulo, division, radians, CORDIC
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !r_batch) begin
            r_mq    <= w_amag;
            r_asign <= w_a[32];
            r_dq    <= vat_pkg::NUM_MAG;
            r_drem  <= '0;
            r_dv    <= w_slmag;
            r_qsign <= w_dneg ^ r_slevel[31];
        end
        if (i_cmd.moddiv) begin
            // quotient of whole degrees first, remainder in the following cycle
            if (i_cmd.cnt == '0) begin
                r_mquo <= 7'(w_mprod >> 24);
            end
            if (i_cmd.cnt == vat_pkg::CNT_WIDTH'(1)) begin
                r_mrem <= 26'({w_mr9, r_mq[15:0]});
            end
            r_dq   <= {r_dq[30:0], w_dbit};
            r_drem <= w_dbit ? 32'(w_dt - {1'b0, r_dv}) : w_dt[31:0];
        end
        if (i_cmd.rad) begin
            r_prad <= 50'(w_rmag[22:0]) * 50'(vat_pkg::DEG_TO_RAD);
            r_flip <= w_flip;
            r_rneg <= w_rr[26];
        end
        if (i_cmd.zload) begin
            r_cx <= vat_pkg::CORDIC_INV_GAIN;
            r_cy <= '0;
            r_cz <= r_rneg ? -$signed({1'b0, w_z}) : $signed({1'b0, w_z});
        end
        if (i_cmd.cordic) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_atan;
            end
        end
    end

    // vertex capture, shared multiplier and accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_used <= '0;
        end else begin
            r_pv <= i_cmd.mul;
            if (i_cmd.accept) begin
                r_used <= '0;
            end else if (r_pv) begin
                r_used[r_tgt] <= 1'b1;
            end
        end
        if (i_cmd.accept) begin
            r_vin <= i_in;
        end
        if (i_cmd.mul) begin
            r_prod <= 65'(w_coef) * 65'(w_coord);
            r_tgt  <= w_tsel;
        end
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.accept) begin
                r_acc[i] <= '0;
            end else if (r_pv && r_tgt == 2'(i)) begin
                r_acc[i] <= r_acc[i] + 66'(r_prod);
            end
        end
    end

    // output register: load on finish, drop on handoff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out.x_out       <= w_res[0];
            r_out.y_out       <= w_res[1];
            r_out.z_out       <= w_res[2];
            r_out.last_out    <= r_vin.last_vertex;
            r_out.scale_fault <= (r_mode == vat_pkg::MODE_SCALE) && r_fault;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

FILE: rtl/core/vertex_affine_transform_unit.sv
// Vertex affine transform unit: one vertex in, one vertex out.
// Vertex rate is set by the shared multiplier steps for rotate and scale; translate/pass
// skips them. A new vertex is taken only once the last one is loaded into the output register.
// First vertex of a batch adds setup: restoring division with the modulo alongside, then
// CORDIC one step a cycle. Output register lets the next vertex enter.
// Synchronous active-low reset clears control, config and batch state.
module vertex_affine_transform_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vat_pkg::t_vtx_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output vat_pkg::t_vtx_out o_out
);

    vat_pkg::t_cmd    w_cmd;
    vat_pkg::t_status w_status;

    // sequence setup and multiply steps
    vat_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // arithmetic and storage
    vat_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
